>>> src/desfr_pkg.sv
// Package with DES round tables and shared types.
`timescale 1ns / 1ps
`default_nettype none
package desfr_pkg;

    localparam int unsigned ROUNDS = 16;
    localparam int unsigned KEY_W = 48;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned BLOCK_W = 64;

    // Action codes carried on the input channel.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_PROC = 1'b1;

    // Controller state.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } desfr_state_t;

    // Data handed from one round cell to the next.
    typedef struct packed {
        logic [HALF_W-1:0] l;
        logic [HALF_W-1:0] r;
    } desfr_half_pair_t;

    // E expansion: entry i (1 = MSB) of the 48-bit result picks this input bit.
    localparam logic [5:0] E_TAB [48] = '{
        6'd32, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd4, 6'd5,
        6'd6, 6'd7, 6'd8, 6'd9, 6'd8, 6'd9, 6'd10, 6'd11,
        6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] P_TAB [32] = '{
        6'd16, 6'd7, 6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1, 6'd15, 6'd23, 6'd26, 6'd5, 6'd18, 6'd31, 6'd10,
        6'd2, 6'd8, 6'd24, 6'd14, 6'd32, 6'd27, 6'd3, 6'd9,
        6'd19, 6'd13, 6'd30, 6'd6, 6'd22, 6'd11, 6'd4, 6'd25
    };

    localparam logic [3:0] SBOX [8][64] = '{
        '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
          4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
          4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
          4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
        '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
          4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
          4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
          4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
        '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
          4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
          4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
          4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
        '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
          4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
          4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
          4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
        '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
          4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
          4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
          4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
        '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
          4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
          4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
          4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
        '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
          4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
          4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
          4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
        '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
          4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
          4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
          4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
    };

    // One DES round function f(R, K).
    function automatic logic [HALF_W-1:0] des_f(input logic [HALF_W-1:0] r,
                                                 input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0]  x;
        logic [HALF_W-1:0] s;
        logic [HALF_W-1:0] p;
        logic [5:0]        grp;
        for (int i = 0; i < 48; i++) begin
            x[47-i] = r[32 - int'(E_TAB[i])];
        end
        x = x ^ k;
        for (int b = 0; b < 8; b++) begin
            grp = x[6*(7-b) +: 6];
            s[4*(7-b) +: 4] = SBOX[b][{grp[5], grp[0], grp[4:1]}];
        end
        for (int i = 0; i < 32; i++) begin
            p[31-i] = s[32 - int'(P_TAB[i])];
        end
        return p;
    endfunction

endpackage
`default_nettype wire

>>> src/desfr_cell.sv
// One Feistel round cell: holds a key and a half pair, passes it on.
`timescale 1ns / 1ps
`default_nettype none
module desfr_cell
    import desfr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 key_we,
    input  wire logic [KEY_W-1:0]     key_in,
    input  wire logic                 load,
    input  wire desfr_half_pair_t     data_in,
    output desfr_half_pair_t          data_out
);

    logic [KEY_W-1:0] key_reg;
    desfr_half_pair_t data_reg;
    desfr_half_pair_t data_next;

    // Round: new L is old R, new R is L xor f(R, K).
    always_comb
    begin
        data_next.l = data_in.r;
        data_next.r = data_in.l ^ des_f(data_in.r, key_reg);
    end

    // Key store for this round.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_reg <= key_in;
        end
    end

    // Result register, taken when the controller steps this cell.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign data_out = data_reg;

endmodule
`default_nettype wire

>>> src/des_feistel_rounds_core.sv
// Top level of the sixteen-round DES Feistel core.
// After acceptance a block steps through a chain of sixteen round cells, one
// round cell firing per cycle; the result then waits in the last cell until
// taken. Load transactions write one cell's round key and give no result.
// One block is in flight at a time.
`timescale 1ns / 1ps
`default_nettype none
module des_feistel_rounds_core
    import desfr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                action,
    input  wire logic [3:0]          key_slot,
    input  wire logic [KEY_W-1:0]    round_key_value,
    input  wire logic [BLOCK_W-1:0]  data_block,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [BLOCK_W-1:0]       preoutput_block
);

    desfr_state_t     state_reg, state_next;
    logic [3:0]       rnd_reg, rnd_next;
    logic [ROUNDS-1:0] step;
    desfr_half_pair_t chain [ROUNDS+1];
    logic             in_fire;

    assign in_fire = in_valid && in_ready;
    assign chain[0] = data_block;

    // Chain of round cells.
    for (genvar g = 0; g < ROUNDS; g++)
    begin : g_cell
        desfr_cell u_cell (
            .clk      (clk),
            .key_we   (in_fire && action == ACT_LOAD && key_slot == 4'(g)),
            .key_in   (round_key_value),
            .load     (step[g]),
            .data_in  (chain[g]),
            .data_out (chain[g+1])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && action == ACT_PROC)
                begin
                    state_next = ST_RUN;
                    rnd_next   = 4'd1;
                end
            end
            ST_RUN:
            begin
                if (rnd_reg == 4'(ROUNDS - 1))
                begin
                    state_next = ST_DONE;
                end
                rnd_next = rnd_reg + 4'd1;
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        step      = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                step[0]  = in_fire && action == ACT_PROC;
            end
            ST_RUN:
            begin
                step[rnd_reg] = 1'b1;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                step = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

    // Preoutput: R16 above, L16 below, i.e. the halves swapped.
    assign preoutput_block = {chain[ROUNDS].r, chain[ROUNDS].l};

    // A result is never offered while input is open.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready and valid overlap");
    // The result is offered once all sixteen cells have stepped after a process transaction.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && action == ACT_PROC) |-> ##16 out_valid)
        else $error("result latency wrong");
    // At most one cell steps per cycle.
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(step)) else $error("multiple cells stepped");

endmodule
`default_nettype wire
